// ===== rtl/core/tpsc_pkg.sv =====
// Shared types and constants for the tone to PWM setting calculator.
`default_nettype none

package tpsc_pkg;

   localparam int ClockW    = 26;
   localparam int FreqW     = 16;
   localparam int VolW      = 8;
   localparam int VolClampW = 7;
   localparam int DividendW = ClockW - 2;
   localparam int RemW      = FreqW;
   localparam int CodeW     = 2;
   localparam int PeriodW   = 8;
   localparam int DutyW     = 10;
   localparam int ProdW     = 15;
   localparam int RecipW    = 15;
   localparam int DutyShift = 20;

   localparam logic [ClockW-1:0]    ClockReset = 26'd32000000;
   localparam logic [VolClampW-1:0] VolumeMax  = 7'd100;
   localparam logic [PeriodW-1:0]   PeriodMax  = 8'd255;
   localparam logic [PeriodW-1:0]   PeriodMin  = 8'd1;
   localparam logic [DividendW-1:0] QuotFit    = 24'd256;
   // ceil(2^20 / 50): exact floor division by 50 for products below 43690
   localparam logic [RecipW-1:0]    DutyRecip  = 15'd20972;

   localparam logic [CodeW-1:0] Prescale1  = 2'd0;
   localparam logic [CodeW-1:0] Prescale4  = 2'd1;
   localparam logic [CodeW-1:0] Prescale16 = 2'd2;
   localparam logic [CodeW-1:0] Prescale64 = 2'd3;

   typedef struct packed {
      logic                 valid;
      logic                 silent;
      logic [VolClampW-1:0] vol;
      logic [FreqW-1:0]     divisor;
      logic [DividendW-1:0] dividend;
      logic [RemW-1:0]      rem;
      logic [DividendW-1:0] quot;
   } div_word_type;

   typedef struct packed {
      logic               timer_update;
      logic [CodeW-1:0]   prescale_code;
      logic [PeriodW-1:0] period;
      logic [DutyW-1:0]   duty;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/tone_pwm_setting_calc.sv =====
// Tone to PWM setting calculator, top level with divider row and output skid.
// Takes one transaction per cycle while the skid register is empty. A row of
// 24 division cells, one quotient bit each, computes (clock_hz / 4) /
// tone_frequency; tpsc_post registers the prescale pick, clamped period and
// duty product, then the scaled duty; one output register presents the result.
// A skid register absorbs the item in flight when the response side stalls,
// and the request side stalls only while that skid register is occupied. The
// clock register may be written only while no transaction is in flight.
`default_nettype none

module tone_pwm_setting_calc (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [25:0] csr_wr_data,   // clock_hz
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,     // tone_frequency[15:0], volume[23:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,     // prescale_code[1:0], period[9:2],
                                           // duty[19:10], zero[23:20]
   output logic             rsp_tuser      // timer_update
);

   localparam int NumCells = tpsc_pkg::DividendW;

   logic [tpsc_pkg::ClockW-1:0] clock_hz_ff;
   logic [tpsc_pkg::FreqW-1:0]  req_freq;
   logic [tpsc_pkg::VolW-1:0]   req_vol;
   logic                        advance;

   tpsc_pkg::div_word_type chain [0:NumCells];

   logic                 tail_valid;
   tpsc_pkg::result_type tail;
   logic                 out_valid_ff;
   tpsc_pkg::result_type out_ff;
   logic                 skid_valid_ff;
   tpsc_pkg::result_type skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= tpsc_pkg::ClockReset;
      end else if (csr_wr_en) begin
         clock_hz_ff <= csr_wr_data;
      end
   end

   assign advance    = !skid_valid_ff;
   assign req_tready = !skid_valid_ff;
   assign req_freq   = req_tdata[tpsc_pkg::FreqW-1:0];
   assign req_vol    = req_tdata[tpsc_pkg::FreqW+tpsc_pkg::VolW-1:tpsc_pkg::FreqW];

   always_comb begin
      chain[0].valid    = req_tvalid && req_tready;
      chain[0].silent   = (req_freq == '0) || (req_vol == '0);
      chain[0].vol      = (req_vol > {1'b0, tpsc_pkg::VolumeMax}) ? tpsc_pkg::VolumeMax
                                                                  : req_vol[6:0];
      chain[0].divisor  = req_freq;
      chain[0].dividend = clock_hz_ff[tpsc_pkg::ClockW-1:2];
      chain[0].rem      = '0;
      chain[0].quot     = '0;
   end

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      tpsc_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .word_in  (chain[i]),
         .word_out (chain[i+1])
      );
   end

   tpsc_post u_post (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .word_in      (chain[NumCells]),
      .result_valid (tail_valid),
      .result       (tail)
   );

   // Refill the output from the skid first, else from the pipeline tail;
   // park the tail in the skid when the output is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= tail_valid;
            out_ff       <= tail;
         end
      end else if (tail_valid && advance) begin
         skid_valid_ff <= 1'b1;
         skid_ff       <= tail;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.timer_update;
   assign rsp_tdata  = {4'd0, out_ff.duty, out_ff.period, out_ff.prescale_code};

   a_silent_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("silent response carries nonzero settings");

   a_period_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[9:2] != '0)
      else $error("timer update with zero period");

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a transaction while output is empty");

   a_stall_holds_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_tready |=> skid_valid_ff && out_valid_ff)
      else $error("stalled transaction lost from output stage");

endmodule

`default_nettype wire

// ===== rtl/core/tpsc_div_cell.sv =====
// One restoring-division cell: retires one quotient bit and hands the word on.
`default_nettype none

module tpsc_div_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire tpsc_pkg::div_word_type word_in,
   output tpsc_pkg::div_word_type      word_out
);

   tpsc_pkg::div_word_type word_ff;
   tpsc_pkg::div_word_type word_in_next;
   logic [tpsc_pkg::RemW:0] rem_shift;
   logic [tpsc_pkg::RemW:0] rem_diff;
   logic                    fits;

   always_comb begin
      rem_shift    = {word_in.rem, word_in.dividend[tpsc_pkg::DividendW-1]};
      rem_diff     = rem_shift - {1'b0, word_in.divisor};
      fits         = (rem_shift >= {1'b0, word_in.divisor});
      word_in_next = word_in;
      word_in_next.dividend = {word_in.dividend[tpsc_pkg::DividendW-2:0], 1'b0};
      word_in_next.rem = fits ? rem_diff[tpsc_pkg::RemW-1:0]
                              : rem_shift[tpsc_pkg::RemW-1:0];
      word_in_next.quot = {word_in.quot[tpsc_pkg::DividendW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in_next;
      end
   end

   assign word_out = word_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tpsc_post.sv =====
// Prescale selection, period clamp and duty scaling behind the divider row.
`default_nettype none

module tpsc_post (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire tpsc_pkg::div_word_type word_in,
   output logic                        result_valid,
   output tpsc_pkg::result_type        result
);

   logic [tpsc_pkg::CodeW-1:0]     code_sel;
   logic [tpsc_pkg::DividendW-1:0] quot_sel;
   logic [tpsc_pkg::PeriodW-1:0]   period_sel;
   logic [tpsc_pkg::PeriodW:0]     period_plus;
   logic [tpsc_pkg::PeriodW+tpsc_pkg::VolClampW-1:0] prod_wide;

   logic                         a_valid_ff;
   logic                         a_silent_ff;
   logic [tpsc_pkg::CodeW-1:0]   a_code_ff;
   logic [tpsc_pkg::PeriodW-1:0] a_period_ff;
   logic [tpsc_pkg::ProdW-1:0]   a_prod_ff;

   logic [tpsc_pkg::ProdW+tpsc_pkg::RecipW-1:0] duty_wide;
   logic                 result_valid_ff;
   tpsc_pkg::result_type result_ff;
   tpsc_pkg::result_type result_in;

   // A quotient at prescale 4^k is the base quotient shifted right by 2k.
   always_comb begin
      if (word_in.quot <= tpsc_pkg::QuotFit) begin
         code_sel = tpsc_pkg::Prescale1;
         quot_sel = word_in.quot;
      end else if ((word_in.quot >> 2) <= tpsc_pkg::QuotFit) begin
         code_sel = tpsc_pkg::Prescale4;
         quot_sel = word_in.quot >> 2;
      end else if ((word_in.quot >> 4) <= tpsc_pkg::QuotFit) begin
         code_sel = tpsc_pkg::Prescale16;
         quot_sel = word_in.quot >> 4;
      end else begin
         code_sel = tpsc_pkg::Prescale64;
         quot_sel = word_in.quot >> 6;
      end

      if (quot_sel > tpsc_pkg::QuotFit) begin
         period_sel = tpsc_pkg::PeriodMax;
      end else if (quot_sel[tpsc_pkg::DividendW-1:1] == '0) begin
         period_sel = tpsc_pkg::PeriodMin;
      end else begin
         period_sel = quot_sel[tpsc_pkg::PeriodW-1:0] - 8'd1;
      end

      period_plus = {1'b0, period_sel} + 9'd1;
      prod_wide   = period_plus * word_in.vol;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff  <= word_in.valid;
         a_silent_ff <= word_in.silent;
         a_code_ff   <= code_sel;
         a_period_ff <= period_sel;
         a_prod_ff   <= prod_wide[tpsc_pkg::ProdW-1:0];
      end
   end

   // (period + 1) * 4 * vol / 200 reduces to the product over 50
   always_comb begin
      duty_wide = a_prod_ff * tpsc_pkg::DutyRecip;
      result_in = '0;
      if (!a_silent_ff) begin
         result_in.timer_update  = 1'b1;
         result_in.prescale_code = a_code_ff;
         result_in.period        = a_period_ff;
         result_in.duty = duty_wide[tpsc_pkg::DutyShift+tpsc_pkg::DutyW-1:tpsc_pkg::DutyShift];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (advance) begin
         result_valid_ff <= a_valid_ff;
         result_ff       <= result_in;
      end
   end

   assign result_valid = result_valid_ff;
   assign result       = result_ff;

endmodule

`default_nettype wire
